[src/ptgt_pkg.sv]
// ----------------------------------------------------------------------------
// ptgt_pkg
// shared constants, types and the arctangent table of the ground track block
// ----------------------------------------------------------------------------
package ptgt_pkg;

  localparam int unsigned CORDIC_STEPS = 24;   // 12 .. 32
  localparam int unsigned CW           = 36;   // cordic datapath width

  localparam logic [39:0] RATE_RESET   = 40'd214088507000;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [24:0] LAT_LIMIT = 25'sd5898240;
  localparam logic signed [24:0] LON_LIMIT = 25'sd11796480;

  typedef logic signed [CW-1:0] cw_t;

  // words riding alongside the cordic data
  typedef struct packed {
    logic        polar;     // x = y = 0 after scaling
    cw_t         z;         // scaled z
    logic [31:0] rot;       // earth rotation angle
    logic [31:0] lon_ang;   // raw longitude angle
  } side_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[src/ptgt_norm.sv]
// ----------------------------------------------------------------------------
// ptgt_norm
// front stages: zero check, rotation product, scaling and half-plane fold
// ----------------------------------------------------------------------------
module ptgt_norm import ptgt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] time_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] z_i,
  input  logic [39:0] rate_i,
  output logic        valid_o,
  output cw_t         x_o,
  output cw_t         y_o,
  output logic [31:0] ang_o,
  output side_t       side_o
);

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [5:0] lead_zeros(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // stage a: register inputs and partial rotation products
  logic        va_q;
  logic [31:0] xa_q, ya_q, za_q;
  logic [63:0] lo_q;
  logic [39:0] hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i && ((x_i | y_i | z_i) != 32'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= x_i;
      ya_q <= y_i;
      za_q <= z_i;
      lo_q <= time_i * rate_i[31:0];
      hi_q <= time_i * rate_i[39:32];
    end
  end

  // stage b: largest magnitude and rounded rotation angle
  logic        vb_q;
  logic [31:0] xb_q, yb_q, zb_q, mb_q, rotb_q;
  logic [31:0] ax, ay, az, mxy;

  assign ax  = abs32(xa_q);
  assign ay  = abs32(ya_q);
  assign az  = abs32(za_q);
  assign mxy = (ay > ax) ? ay : ax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xb_q   <= xa_q;
      yb_q   <= ya_q;
      zb_q   <= za_q;
      mb_q   <= (az > mxy) ? az : mxy;
      rotb_q <= lo_q[63:32] + hi_q[31:0] + {31'd0, lo_q[31]};
    end
  end

  // stage c: scale so the largest magnitude lands in [2^30, 2^31]
  logic        vc_q;
  logic [32:0] xc_q, yc_q, zc_q;
  logic [31:0] rotc_q;
  logic [5:0]  lz;
  logic [4:0]  sh;

  assign lz = lead_zeros(mb_q);
  assign sh = mb_q[31] ? 5'd0 : 5'(lz - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xc_q   <= {xb_q[31], xb_q} << sh;
      yc_q   <= {yb_q[31], yb_q} << sh;
      zc_q   <= {zb_q[31], zb_q} << sh;
      rotc_q <= rotb_q;
    end
  end

  // stage d: fold left half-plane, flag polar points
  logic        vd_q;
  cw_t         xd_q, yd_q;
  logic [31:0] angd_q;
  side_t       sided_q;
  cw_t         xe, ye, ze;

  assign xe = CW'($signed(xc_q));
  assign ye = CW'($signed(yc_q));
  assign ze = CW'($signed(zc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xd_q            <= xe[CW-1] ? -xe : xe;
      yd_q            <= xe[CW-1] ? -ye : ye;
      angd_q          <= xe[CW-1] ? HALF_TURN : 32'd0;
      sided_q.polar   <= (xc_q == 33'd0) && (yc_q == 33'd0);
      sided_q.z       <= ze;
      sided_q.rot     <= rotc_q;
      sided_q.lon_ang <= 32'd0;
    end
  end

  assign valid_o = vd_q;
  assign x_o     = xd_q;
  assign y_o     = yd_q;
  assign ang_o   = angd_q;
  assign side_o  = sided_q;

endmodule

[src/ptgt_cordic.sv]
// ----------------------------------------------------------------------------
// ptgt_cordic
// vectoring cordic, one registered stage per iteration
// ----------------------------------------------------------------------------
module ptgt_cordic import ptgt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  cw_t         x_i,
  input  cw_t         y_i,
  input  logic [31:0] ang_i,
  input  side_t       side_i,
  output logic        valid_o,
  output cw_t         x_o,
  output logic [31:0] ang_o,
  output side_t       side_o
);

  logic [CORDIC_STEPS-1:0] v_q;
  cw_t                     x_q [CORDIC_STEPS];
  cw_t                     y_q [CORDIC_STEPS];
  logic [31:0]             a_q [CORDIC_STEPS];
  side_t                   s_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic        v_in;
    cw_t         x_in, y_in;
    logic [31:0] a_in;
    side_t       s_in;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign a_in = ang_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign a_in = a_q[i-1];
      assign s_in = s_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    // y >= 0 rotates clockwise
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[CW-1]) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          a_q[i] <= a_in + atan_turns(5'(i));
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          a_q[i] <= a_in - atan_turns(5'(i));
        end
        s_q[i] <= s_in;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STEPS-1];
  assign x_o     = x_q[CORDIC_STEPS-1];
  assign ang_o   = a_q[CORDIC_STEPS-1];
  assign side_o  = s_q[CORDIC_STEPS-1];

endmodule

[src/ptgt_deg.sv]
// ----------------------------------------------------------------------------
// ptgt_deg
// back stages: polar override, rotation correction, degrees, clamping
// ----------------------------------------------------------------------------
module ptgt_deg import ptgt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] lat_ang_i,
  input  side_t       side_i,
  output logic        valid_o,
  output logic [23:0] lat_o,
  output logic [24:0] lon_o
);

  function automatic logic signed [24:0] to_deg(input logic [31:0] a);
    logic signed [40:0] s, p;
    s = 41'($signed(a));
    p = (s <<< 8) + (s <<< 6) + (s <<< 5) + (s <<< 3) + 41'sd32768;
    return 25'(p >>> 16);
  endfunction

  logic [31:0] lat_a, lon_a;

  assign lat_a = side_i.polar ? (side_i.z[CW-1] ? -QUARTER_TURN : QUARTER_TURN) : lat_ang_i;
  assign lon_a = (side_i.polar ? 32'd0 : side_i.lon_ang) - side_i.rot;

  // stage 1: degree conversion
  logic              v1_q;
  logic signed [24:0] lat1_q, lon1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lat1_q <= to_deg(lat_a);
      lon1_q <= to_deg(lon_a);
    end
  end

  // stage 2: clamp and output register
  logic        v2_q;
  logic [23:0] lat2_q;
  logic [24:0] lon2_q;
  logic signed [24:0] lat_c;

  always_comb begin
    lat_c = lat1_q;
    if (lat1_q > LAT_LIMIT) lat_c = LAT_LIMIT;
    if (lat1_q < -LAT_LIMIT) lat_c = -LAT_LIMIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lat2_q <= lat_c[23:0];
      lon2_q <= (lon1_q <= -LON_LIMIT) ? LON_LIMIT : lon1_q;
    end
  end

  assign valid_o = v2_q;
  assign lat_o   = lat2_q;
  assign lon_o   = lon2_q;

endmodule

[src/position_to_ground_track_lat_lon.sv]
// ----------------------------------------------------------------------------
// position_to_ground_track_lat_lon
// inertial position and time to geocentric latitude and earth-fixed longitude
// ----------------------------------------------------------------------------
// One word per cycle goes in and one result per cycle comes out while the
// master side does not stall; the two chained cordic pipelines have one
// registered stage per iteration. A zero vector is dropped and gives no
// output word. A stall on the master side freezes the whole pipeline, so
// nothing is lost or repeated. The rotation rate register (2^-64 turn per
// ms) may be written at any time the block is empty; its write channel is
// always ready.
// ----------------------------------------------------------------------------
module position_to_ground_track_lat_lon import ptgt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config: rotation_rate
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [39:0]  cfg_data_i,
  // input words
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // time_ms, pos_x, pos_y, pos_z
  // result words
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [55:0]  m_axis_tdata_o   // latitude_deg, longitude_deg, zero pad
);

  logic [39:0] rate_q;

  // pipeline advances whenever the output slot is free or being taken
  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // front: scaling and fold
  logic        nv;
  cw_t         nx, ny;
  logic [31:0] na;
  side_t       ns;

  ptgt_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .time_i  (s_axis_tdata_i[31:0]),
    .x_i     (s_axis_tdata_i[63:32]),
    .y_i     (s_axis_tdata_i[95:64]),
    .z_i     (s_axis_tdata_i[127:96]),
    .rate_i  (rate_q),
    .valid_o (nv),
    .x_o     (nx),
    .y_o     (ny),
    .ang_o   (na),
    .side_o  (ns)
  );

  // longitude cordic on (x, y)
  logic        lv;
  cw_t         lx;
  logic [31:0] la;
  side_t       ls;

  ptgt_cordic u_cordic_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv),
    .x_i     (nx),
    .y_i     (ny),
    .ang_i   (na),
    .side_i  (ns),
    .valid_o (lv),
    .x_o     (lx),
    .ang_o   (la),
    .side_o  (ls)
  );

  // gain correction of the planar magnitude; x is non-negative here
  logic        mv_q;
  cw_t         mr_q;
  side_t       ms_q;
  logic [63:0] prod;

  assign prod = lx[33:0] * INV_GAIN_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= lv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mr_q         <= CW'(prod[63:30]);
      ms_q.polar   <= ls.polar;
      ms_q.z       <= ls.z;
      ms_q.rot     <= ls.rot;
      ms_q.lon_ang <= la;
    end
  end

  // latitude cordic on (magnitude, z)
  logic        tv;
  logic [31:0] ta;
  side_t       ts;

  ptgt_cordic u_cordic_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mv_q),
    .x_i     (mr_q),
    .y_i     (ms_q.z),
    .ang_i   (32'd0),
    .side_i  (ms_q),
    .valid_o (tv),
    .x_o     (),
    .ang_o   (ta),
    .side_o  (ts)
  );

  // back: degrees and output register
  logic [23:0] lat;
  logic [24:0] lon;

  ptgt_deg u_deg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (tv),
    .lat_ang_i (ta),
    .side_i    (ts),
    .valid_o   (m_axis_tvalid_o),
    .lat_o     (lat),
    .lon_o     (lon)
  );

  assign m_axis_tdata_o = {7'd0, lon, lat};

endmodule

[src/ptgt_checker.sv]
// ----------------------------------------------------------------------------
// ptgt_checker
// port-level checks of the ground track block
// ----------------------------------------------------------------------------
module ptgt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [55:0]  m_axis_tdata_o
);

  // held result word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // an empty output slot never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with free output");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[23:0]) <= 24'sd5898240) &&
                        ($signed(m_axis_tdata_o[23:0]) >= -24'sd5898240))
    else $error("latitude out of range");

  a_lon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[48:24]) <= 25'sd11796480) &&
                        ($signed(m_axis_tdata_o[48:24]) > -25'sd11796480))
    else $error("longitude out of range");

endmodule

bind position_to_ground_track_lat_lon ptgt_checker u_ptgt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[verif/ground_track_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ground_track_checker
// predicts latitude and longitude for every accepted non-zero position word and
// compares them, in order, with the result words of the block
// ----------------------------------------------------------------------------
module ground_track_checker import ptgt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [39:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [55:0]  m_tdata_i,
  output int           errors_o,
  output int           pending_o
);

  typedef struct packed {
    logic signed [23:0] lat;
    logic signed [24:0] lon;
  } track_t;

  logic [39:0] rate_q;
  track_t      track_q[$];

  localparam logic [31:0] ATAN_TAB [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  // vectoring rotation towards y = 0, floor shifts, angle in 2^-32 turn
  function automatic logic [31:0] vector_angle(inout longint x, inout longint y,
                                               input logic [31:0] start);
    logic [31:0] a;
    longint dx, dy;
    a = start;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; a += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; a -= ATAN_TAB[i];
      end
    end
    return a;
  endfunction

  function automatic longint turns_to_deg(input logic [31:0] a);
    longint s;
    s = longint'(signed'(a));
    return (s * 360 + 32768) >>> 16;
  endfunction

  // returns 0 for a zero vector, which yields no result word
  function automatic bit track_of(input logic [127:0] w, input logic [39:0] rate,
                                  output track_t res);
    longint x, y, z, m, rx, rz, lat, lon;
    logic [63:0] t, lo, sum;
    logic [31:0] lon_ang, rot, start;
    t = {32'd0, w[31:0]};
    x = longint'(signed'(w[63:32]));
    y = longint'(signed'(w[95:64]));
    z = longint'(signed'(w[127:96]));
    if (x == 0 && y == 0 && z == 0) return 0;
    m = (x < 0) ? -x : x;
    if ((y < 0 ? -y : y) > m) m = (y < 0) ? -y : y;
    if ((z < 0 ? -z : z) > m) m = (z < 0) ? -z : z;
    while (m < 64'h4000_0000) begin
      m <<= 1; x <<= 1; y <<= 1; z <<= 1;
    end
    if (x == 0 && y == 0) begin
      lon_ang = '0;
      lat = (z > 0) ? 64'sh4000_0000 : -64'sh4000_0000;
    end else begin
      start = '0;
      if (x < 0) begin
        x = -x; y = -y; start = HALF_TURN;
      end
      lon_ang = vector_angle(x, y, start);
      rx = longint'((64'(x) * 64'd652032874) >> 30);
      rz = z;
      lat = longint'(signed'(vector_angle(rx, rz, 32'd0)));
    end
    lo  = t * {32'd0, rate[31:0]};
    sum = (lo >> 32) + t * {56'd0, rate[39:32]} + (({32'd0, lo[31:0]} + 64'h8000_0000) >> 32);
    rot = sum[31:0];
    lat = (lat * 360 + 32768) >>> 16;
    if (lat > 5898240) lat = 5898240;
    if (lat < -5898240) lat = -5898240;
    lon = turns_to_deg(lon_ang - rot);
    if (lon <= -11796480) lon = 11796480;
    res.lat = lat[23:0];
    res.lon = lon[24:0];
    return 1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    track_t  exp_t, got;
    if (!rst_ni) begin
      rate_q   <= RATE_RESET;
      errors_o <= 0;
      track_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) rate_q <= cfg_data_i;
      if (s_tvalid_i && s_tready_i && track_of(s_tdata_i, rate_q, exp_t))
        track_q.push_back(exp_t);
      if (m_tvalid_i && m_tready_i) begin
        got.lat = m_tdata_i[23:0];
        got.lon = m_tdata_i[48:24];
        if (track_q.size() == 0) begin
          $display("%0t: unexpected word lat %0d lon %0d", $time, got.lat, got.lon);
          errors_o <= errors_o + 1;
        end else begin
          exp_t = track_q.pop_front();
          if (got.lat !== exp_t.lat || got.lon !== exp_t.lon || m_tdata_i[55:49] !== '0) begin
            $display("%0t: mismatch expected lat %0d lon %0d, actual lat %0d lon %0d",
                     $time, exp_t.lat, exp_t.lon, got.lat, got.lon);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = track_q.size();

endmodule

[verif/position_to_ground_track_lat_lon_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_to_ground_track_lat_lon_tb
// drives position words through several rotation rates with random gaps and
// stalls; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module position_to_ground_track_lat_lon_tb import ptgt_pkg::*;;

  localparam int LATENCY = 60;
  localparam int LIMIT   = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [39:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [55:0]  m_axis_tdata_o;
  int           errors, pending, cycles;
  bit           long_hold = 1'b0;   // receiver stall requested by the sender
  bit           hold_taken = 1'b0;  // receiver has served the request
  bit           done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  position_to_ground_track_lat_lon u_top (.*);

  ground_track_checker u_check (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o), .s_tdata_i(s_axis_tdata_i),
    .m_tvalid_i(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i), .m_tdata_i(m_axis_tdata_o),
    .errors_o(errors), .pending_o(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // random coordinate, mostly full range, sometimes tiny or extreme
  function automatic logic [31:0] coord();
    case ($urandom_range(7))
      0: return 32'($signed($urandom_range(8)) - 4);
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return '0;
      3: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [31:0] t, x, y, z);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, y, x, t};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // block must be empty before a rate write
  task automatic write_rate(input logic [39:0] rate);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stalls, one long hold on request
  always @(posedge clk_i) begin
    int n;
    if (long_hold && !hold_taken) begin
      hold_taken = 1'b1;
      m_axis_tready_i <= 1'b0;
      repeat (300) @(posedge clk_i);
    end
    n = gap_len();
    if (!done && n > 0 && $urandom_range(3) != 0) begin
      m_axis_tready_i <= 1'b0;
      repeat (n - 1) @(posedge clk_i);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [39:0] rates [5];
    rates = '{RATE_RESET, 40'd0, 40'hff_ffff_ffff, 40'd1, 40'h80_0000_0000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero vector, poles, axes, the -180 fold
    send_word(32'd0, 32'd0, 32'd0, 32'd0);
    send_word(32'd0, 32'd0, 32'd0, 32'd5);
    send_word(32'd0, 32'd0, 32'd0, 32'h8000_0000);
    send_word(32'hffff_ffff, 32'h7fff_ffff, 32'd0, 32'd0);
    send_word(32'd0, 32'h8000_0000, 32'd0, 32'd0);
    send_word(32'd0, 32'h8000_0000, 32'hffff_ffff, 32'd0);
    send_word(32'd0, 32'h8000_0000, 32'd1, 32'd0);
    send_word(32'd1000, 32'd1, 32'd1, 32'd1);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(32'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_word(32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_word(32'd86164000, 32'd0, 32'h7fff_ffff, 32'd0);
    send_word(32'd0, 32'd0, 32'h8000_0000, 32'd3);

    // pause until drained
    idle(1);
    while (pending != 0) @(posedge clk_i);

    for (int ph = 0; ph < 5; ph++) begin
      write_rate(ph == 4 ? 40'($urandom) << 8 | 40'($urandom_range(255)) : rates[ph]);
      if (ph == 1) long_hold = 1'b1;  // fill up the pipeline against a stalled sink
      for (int k = 0; k < 350; k++) begin
        send_word($urandom_range(3) == 0 ? $urandom_range(100000) : $urandom,
                  coord(), coord(), coord());
        if (ph != 1 || k > 100) idle(gap_len());
      end
    end
    write_rate(rates[4]);
    send_word(32'hffff_ffff, 32'h8000_0000, 32'd0, 32'd1);

    s_axis_tvalid_i <= 1'b0;
    done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
